FILE: rtl/core/lidar_scan_box_collision_detect_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lidar scan box collision detector
// Short forms for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_BOX_COLLISION_DETECT_MACROS_SVH
`define LIDAR_SCAN_BOX_COLLISION_DETECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSBCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSBCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lsbcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcd_pkg
// Shared types, constants and the CORDIC arctangent table of the collision
// detector.
// ----------------------------------------------------------------------------
package lsbcd_pkg;

  // Default sizes
  localparam int MAX_SAMPLES_DEF  = 4096;
  localparam int CORDIC_STEPS_DEF = 16;

  // Step counter covers up to 32 rotations
  localparam int STEP_W    = 5;
  localparam int DATA_W    = 16;
  localparam int IDX_OUT_W = 12;
  localparam int REG_IDX_W = 2;

  // CORDIC word widths: x/y carry Q1.15 plus growth, z in 2^-32 turn
  localparam int XY_W   = 18;
  localparam int Z_W    = 33;
  localparam int PROD_W = 36;

  // 0.60725 in Q1.15
  localparam logic signed [XY_W-1:0] GAIN_Q15 = 18'sd19898;

  localparam logic [DATA_W-1:0] HALF_SIDE_RESET = 16'd600;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEADING     = 2'd0,
    REG_ANGLE_START = 2'd1,
    REG_ANGLE_STEP  = 2'd2,
    REG_HALF_SIDE   = 2'd3
  } reg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_MUL,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;
    logic              iter;
    logic              mul;
    logic              finish;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  // round(atan(2^-i) / (2*pi) * 2^32); later steps reuse the last entry
  function automatic logic signed [Z_W-1:0] atan_turn32(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:  a = 33'sd536870912;
      5'd1:  a = 33'sd316933406;
      5'd2:  a = 33'sd167458907;
      5'd3:  a = 33'sd85004756;
      5'd4:  a = 33'sd42667331;
      5'd5:  a = 33'sd21354465;
      5'd6:  a = 33'sd10679838;
      5'd7:  a = 33'sd5340245;
      5'd8:  a = 33'sd2670163;
      5'd9:  a = 33'sd1335087;
      5'd10: a = 33'sd667544;
      5'd11: a = 33'sd333772;
      5'd12: a = 33'sd166886;
      5'd13: a = 33'sd83443;
      5'd14: a = 33'sd41722;
      5'd15: a = 33'sd20861;
      5'd16: a = 33'sd10430;
      5'd17: a = 33'sd5215;
      5'd18: a = 33'sd2608;
      5'd19: a = 33'sd1304;
      5'd20: a = 33'sd652;
      5'd21: a = 33'sd326;
      5'd22: a = 33'sd163;
      default: a = 33'sd81;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/lsbcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcd_ctrl
// Sequencer: accepts a sample, steps the CORDIC, issues the multiply and
// the box test, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module lsbcd_ctrl #(
  parameter int CORDIC_STEPS = lsbcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lsbcd_pkg::dp_cmd_t cmd
);

  localparam logic [lsbcd_pkg::STEP_W-1:0] LAST_STEP =
    lsbcd_pkg::STEP_W'(CORDIC_STEPS - 1);

  lsbcd_pkg::state_t              state, state_next;
  logic [lsbcd_pkg::STEP_W-1:0]   cnt, cnt_next;
  logic                           out_valid_next;

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsbcd_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = cnt;
    case (state)
      lsbcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = lsbcd_pkg::ST_ITER;
        end
      end
      lsbcd_pkg::ST_ITER: begin
        cmd.iter = 1'b1;
        if (cnt == LAST_STEP) begin
          state_next = lsbcd_pkg::ST_MUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      lsbcd_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = lsbcd_pkg::ST_DONE;
      end
      lsbcd_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = lsbcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lsbcd_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: rtl/core/lsbcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcd_dp
// Datapath: configuration registers, scan state, iterative CORDIC, range
// products, box test and result register.
// ----------------------------------------------------------------------------
module lsbcd_dp #(
  parameter int MAX_SAMPLES = lsbcd_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lsbcd_pkg::dp_cmd_t                   cmd,
  input  logic                                 cfg_we,
  input  logic [lsbcd_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [lsbcd_pkg::DATA_W-1:0]         cfg_data,
  input  logic [lsbcd_pkg::DATA_W-1:0]         range_mm,
  input  logic                                 first_of_scan,
  input  logic                                 last_of_scan,
  output logic                                 inside_box,
  output logic                                 collision_warning,
  output logic [lsbcd_pkg::IDX_OUT_W-1:0]      sample_index,
  output logic                                 scan_done
);

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  localparam int DW = lsbcd_pkg::DATA_W;
  localparam int XW = lsbcd_pkg::XY_W;
  localparam int ZW = lsbcd_pkg::Z_W;
  localparam int PW = lsbcd_pkg::PROD_W;

  // Configuration
  logic [DW-1:0] heading, angle_start, angle_step, half_side_mm;

  // Scan state
  logic [IDX_W-1:0] beam_index;
  logic [DW-1:0]    beam_angle;
  logic             hit_seen;
  logic             scan_closed;

  // Work registers
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [DW-1:0]        range_r;
  logic                 last_r;
  logic signed [PW-1:0] prod_x, prod_y;

  logic                 new_scan;
  logic [DW-1:0]        eff_angle, theta, theta_fold;
  logic signed [ZW-1:0] z_init;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] atan_a;
  logic signed [PW-1:0] bound;
  logic                 in_box;

  // Angle of this sample, folded to within a quarter turn of zero; the fold
  // negates cos and sin, which the symmetric box test ignores
  always_comb begin
    new_scan   = first_of_scan || scan_closed;
    eff_angle  = new_scan ? angle_start : beam_angle;
    theta      = heading + eff_angle;
    theta_fold = (theta[DW-1] ^ theta[DW-2]) ? (theta ^ 16'h8000) : theta;
    z_init     = {theta_fold[DW-1], theta_fold, 16'h0000};
  end

  // One CORDIC rotation
  always_comb begin
    dx     = y >>> cmd.step;
    dy     = x >>> cmd.step;
    atan_a = lsbcd_pkg::atan_turn32(cmd.step);
  end

  // Box test against +-half_side in Q15 scale
  always_comb begin
    bound  = signed'(PW'({half_side_mm, 15'h0000}));
    in_box = (prod_x >= -bound) && (prod_x <= bound) &&
             (prod_y >= -bound) && (prod_y <= bound);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      heading      <= '0;
      angle_start  <= '0;
      angle_step   <= '0;
      half_side_mm <= lsbcd_pkg::HALF_SIDE_RESET;
    end else if (cfg_we) begin
      case (lsbcd_pkg::reg_idx_t'(cfg_index))
        lsbcd_pkg::REG_HEADING:     heading      <= cfg_data;
        lsbcd_pkg::REG_ANGLE_START: angle_start  <= cfg_data;
        lsbcd_pkg::REG_ANGLE_STEP:  angle_step   <= cfg_data;
        lsbcd_pkg::REG_HALF_SIDE:   half_side_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan state: restart on a load that opens a new scan, advance on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index  <= '0;
      beam_angle  <= '0;
      hit_seen    <= 1'b0;
      scan_closed <= 1'b0;
    end else if (cmd.load) begin
      if (new_scan) begin
        beam_index <= '0;
        hit_seen   <= 1'b0;
      end
      beam_angle <= eff_angle;
    end else if (cmd.finish) begin
      beam_index  <= (beam_index == IDX_LAST) ? '0 : beam_index + 1'b1;
      beam_angle  <= beam_angle + angle_step;
      hit_seen    <= hit_seen | in_box;
      scan_closed <= last_r;
    end
  end

  // CORDIC and products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x       <= lsbcd_pkg::GAIN_Q15;
      y       <= '0;
      z       <= z_init;
      range_r <= range_mm;
      last_r  <= last_of_scan;
    end else if (cmd.iter) begin
      if (!z[ZW-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_a;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_a;
      end
    end
    if (cmd.mul) begin
      prod_x <= PW'(signed'({1'b0, range_r}) * x);
      prod_y <= PW'(signed'({1'b0, range_r}) * y);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      inside_box        <= in_box;
      collision_warning <= in_box && !hit_seen;
      sample_index      <= lsbcd_pkg::IDX_OUT_W'(beam_index);
      scan_done         <= last_r;
    end
  end

endmodule

FILE: rtl/core/lidar_scan_box_collision_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_box_collision_detect
// Flags lidar samples whose rotated point falls in a square box around the
// robot and raises a warning on the first such sample of each scan.
// ----------------------------------------------------------------------------
// Each sample passes the states IDLE, where the request is taken, ITER,
// where the single CORDIC unit does one rotation per cycle, MUL for the
// two range products and DONE for the box test. One sample is in work at
// a time; the next one is taken while the previous result still waits in
// the output register, and the box test holds while that register is full.
// Configuration writes are taken in any cycle and should be made only while
// no sample is in work.
module lidar_scan_box_collision_detect #(
  parameter int MAX_SAMPLES  = lsbcd_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STEPS = lsbcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // range_mm[15:0]
  input  logic [15:0] s_axis_tdata,
  // first_of_scan[0]
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // inside_box[0], collision_warning[1], sample_index[13:2], zero[15:14]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lsbcd_pkg::dp_cmd_t                 cmd;
  logic                               inside_box;
  logic                               collision_warning;
  logic [lsbcd_pkg::IDX_OUT_W-1:0]    sample_index;

  // Registers always take a write
  assign cfg_ready = 1'b1;

  lsbcd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd      (cmd)
  );

  lsbcd_dp #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .range_mm         (s_axis_tdata),
    .first_of_scan    (s_axis_tuser[0]),
    .last_of_scan     (s_axis_tlast),
    .inside_box       (inside_box),
    .collision_warning(collision_warning),
    .sample_index     (sample_index),
    .scan_done        (m_axis_tlast)
  );

  // Pack the result
  assign m_axis_tdata = {2'b00, sample_index, collision_warning, inside_box};

endmodule

FILE: rtl/core/lsbcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcd_checker
// Port-level checks of the collision detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_scan_box_collision_detect_macros.svh"

module lsbcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // A warning only ever comes with an inside sample
  `LSBCD_ASSERT_SAME(a_warn_inside, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0], "warning without inside flag")

  // A taken request keeps the input closed while the CORDIC runs
  `LSBCD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

  // No result shows up right after a request is taken with the output empty
  `LSBCD_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result too early")

  // A stalled result holds
  `LSBCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind lidar_scan_box_collision_detect lsbcd_checker u_lsbcd_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);
